FILE: hdl/eul2q_pkg.sv
// Shared types, constants and rounding helpers for the Euler-to-quaternion block.
`timescale 1ns / 1ps
package eul2q_pkg;

  localparam int NSTEPS     = 17;
  localparam int CW         = 34;
  localparam int ZW         = 20;
  localparam int QW         = 32;
  localparam int QF         = 30;
  localparam int CORDIC_LAT = NSTEPS + 2;

  typedef logic signed [15:0]   angle_t;
  typedef logic signed [15:0]   q14_t;
  typedef logic signed [QW-1:0] q30_t;
  typedef logic signed [CW-1:0] cvec_t;
  typedef logic signed [ZW-1:0] cang_t;

  localparam cang_t PI_Q16      = 20'sd205887;
  localparam cang_t HALF_PI_Q16 = 20'sd102944;
  localparam cvec_t CORDIC_K    = 34'sd652032875;

  localparam cang_t ATAN_TAB [NSTEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2, 20'sd1
  };

  localparam logic signed [2*QW-1:0] RND_Q30 = 64'sd536870912;

  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic signed [2*QW-1:0] p;
    p = (2*QW)'(a) * (2*QW)'(b) + RND_Q30;
    return p[QF +: QW];
  endfunction

endpackage

FILE: hdl/eul2q_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of half an angle.
`timescale 1ns / 1ps
module eul2q_cordic (
  input  logic            clk_i,
  input  eul2q_pkg::angle_t angle_i,
  output eul2q_pkg::q30_t cos_o,
  output eul2q_pkg::q30_t sin_o
);
  import eul2q_pkg::*;

  cvec_t x_q [0:NSTEPS];
  cvec_t y_q [0:NSTEPS];
  cang_t z_q [0:NSTEPS];
  logic  flip_q [0:NSTEPS];
  cang_t z0_d;
  cang_t zf_d;
  logic  flip_d;
  q30_t  cos_q, sin_q;

  always_comb begin
    z0_d = cang_t'({{(ZW-18){angle_i[15]}}, angle_i, 2'b00});
    zf_d = z0_d;
    flip_d = 1'b0;
    if (z0_d > HALF_PI_Q16) begin
      zf_d = z0_d - PI_Q16;
      flip_d = 1'b1;
    end else if (z0_d < -HALF_PI_Q16) begin
      zf_d = z0_d + PI_Q16;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= CORDIC_K;
    y_q[0]    <= '0;
    z_q[0]    <= zf_d;
    flip_q[0] <= flip_d;
  end

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    cvec_t dx, dy, x_d, y_d;
    cang_t z_d;
    always_comb begin
      dx = y_q[i] >>> i;
      dy = x_q[i] >>> i;
      if (z_q[i] >= 0) begin
        x_d = x_q[i] - dx;
        y_d = y_q[i] + dy;
        z_d = z_q[i] - ATAN_TAB[i];
      end else begin
        x_d = x_q[i] + dx;
        y_d = y_q[i] - dy;
        z_d = z_q[i] + ATAN_TAB[i];
      end
    end
    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_d;
      y_q[i+1]    <= y_d;
      z_q[i+1]    <= z_d;
      flip_q[i+1] <= flip_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= flip_q[NSTEPS] ? q30_t'(-x_q[NSTEPS]) : q30_t'(x_q[NSTEPS]);
    sin_q <= flip_q[NSTEPS] ? q30_t'(-y_q[NSTEPS]) : q30_t'(y_q[NSTEPS]);
  end

  // z of the last step is a residual only
  logic unused_z;
  assign unused_z = ^z_q[NSTEPS];

  assign cos_o = cos_q;
  assign sin_o = sin_q;
endmodule

FILE: hdl/eul2q_combine.sv
// Three-stage product, sum, round and saturate path forming the quaternion.
`timescale 1ns / 1ps
module eul2q_combine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  eul2q_pkg::q30_t cr_i,
  input  eul2q_pkg::q30_t sr_i,
  input  eul2q_pkg::q30_t cp_i,
  input  eul2q_pkg::q30_t sp_i,
  input  eul2q_pkg::q30_t cy_i,
  input  eul2q_pkg::q30_t sy_i,
  output logic            valid_o,
  output eul2q_pkg::q14_t quat_w_o,
  output eul2q_pkg::q14_t quat_x_o,
  output eul2q_pkg::q14_t quat_y_o,
  output eul2q_pkg::q14_t quat_z_o
);
  import eul2q_pkg::*;

  localparam logic signed [QW+1:0] RND_Q14 = 34'sd32768;
  localparam logic signed [QW-15:0] ONE_Q14 = 18'sd16384;

  function automatic q14_t to_q14(input logic signed [QW:0] v);
    logic signed [QW+1:0]  s;
    logic signed [QW-15:0] r;
    s = {v[QW], v} + RND_Q14;
    r = s[QW+1:16];
    if (r > ONE_Q14) begin
      r = ONE_Q14;
    end else if (r < -ONE_Q14) begin
      r = -ONE_Q14;
    end
    return r[15:0];
  endfunction

  logic vld_a_q, vld_b_q, vld_c_q;
  q30_t cc_q, ss_q, sc_q, cs_q, cy_q, sy_q;
  q30_t ccc_q, sss_q, scc_q, css_q, csc_q, scs_q, ccs_q, ssc_q;
  q14_t w_q, x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cc_q <= mul_q30(cr_i, cp_i);
    ss_q <= mul_q30(sr_i, sp_i);
    sc_q <= mul_q30(sr_i, cp_i);
    cs_q <= mul_q30(cr_i, sp_i);
    cy_q <= cy_i;
    sy_q <= sy_i;
  end

  always_ff @(posedge clk_i) begin
    ccc_q <= mul_q30(cc_q, cy_q);
    sss_q <= mul_q30(ss_q, sy_q);
    scc_q <= mul_q30(sc_q, cy_q);
    css_q <= mul_q30(cs_q, sy_q);
    csc_q <= mul_q30(cs_q, cy_q);
    scs_q <= mul_q30(sc_q, sy_q);
    ccs_q <= mul_q30(cc_q, sy_q);
    ssc_q <= mul_q30(ss_q, cy_q);
  end

  always_ff @(posedge clk_i) begin
    w_q <= to_q14({ccc_q[QW-1], ccc_q} + {sss_q[QW-1], sss_q});
    x_q <= to_q14({scc_q[QW-1], scc_q} - {css_q[QW-1], css_q});
    y_q <= to_q14({csc_q[QW-1], csc_q} + {scs_q[QW-1], scs_q});
    z_q <= to_q14({ccs_q[QW-1], ccs_q} - {ssc_q[QW-1], ssc_q});
  end

  assign valid_o  = vld_c_q;
  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;
endmodule

FILE: hdl/euler_to_quaternion_top.sv
// Top level: ZYX Euler angles (Q2.13) to unit quaternion (Q1.14), fully pipelined.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------
//   request   | start_i / busy_o   | roll_x_i, pitch_y_i, yaw_z_i (Q2.13)
//   result    | valid_o (strobe)   | quat_w_o, quat_x_o, quat_y_o, quat_z_o
//
// One request per cycle; busy_o is always low.
// Each request passes the CORDIC pipeline (fold, 17 steps, sign) and then
// the product path (two multiply ranks, then sum and saturate).
// Reset clears only the valid bits; data registers run freely.
// Each result shows on valid_o for one cycle and cannot be held off.
`timescale 1ns / 1ps
module euler_to_quaternion_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  eul2q_pkg::angle_t roll_x_i,
  input  eul2q_pkg::angle_t pitch_y_i,
  input  eul2q_pkg::angle_t yaw_z_i,
  output logic              valid_o,
  output eul2q_pkg::q14_t   quat_w_o,
  output eul2q_pkg::q14_t   quat_x_o,
  output eul2q_pkg::q14_t   quat_y_o,
  output eul2q_pkg::q14_t   quat_z_o
);
  import eul2q_pkg::*;

  logic [CORDIC_LAT-1:0] vld_q;
  q30_t cr, sr, cp, sp, cy, sy;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CORDIC_LAT-2:0], start_i & ~busy_o};
    end
  end

  eul2q_cordic u_cordic_r (
    .clk_i   (clk_i),
    .angle_i (roll_x_i),
    .cos_o   (cr),
    .sin_o   (sr)
  );

  eul2q_cordic u_cordic_p (
    .clk_i   (clk_i),
    .angle_i (pitch_y_i),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  eul2q_cordic u_cordic_y (
    .clk_i   (clk_i),
    .angle_i (yaw_z_i),
    .cos_o   (cy),
    .sin_o   (sy)
  );

  eul2q_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_q[CORDIC_LAT-1]),
    .cr_i     (cr),
    .sr_i     (sr),
    .cp_i     (cp),
    .sp_i     (sp),
    .cy_i     (cy),
    .sy_i     (sy),
    .valid_o  (valid_o),
    .quat_w_o (quat_w_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o)
  );
endmodule
